// ===== src/laplacian_edge_filter_rgb_core_assert.svh =====
// ----------------------------------------------------------------------------
// laplacian edge filter assertion macros
// shared property forms for the filter core checks
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_EDGE_FILTER_RGB_CORE_ASSERT_SVH
`define LAPLACIAN_EDGE_FILTER_RGB_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define LEF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define LEF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lefrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// lefrgb_pkg
// types and constants for the rgb four-neighbour laplacian filter
// ----------------------------------------------------------------------------
package lefrgb_pkg;

   localparam int CHAN_W  = 8;
   localparam int MAG_W   = 10;
   localparam int WIDTH_W = 11;
   localparam int ROW_W   = 12;
   localparam int CCOL_W  = 10;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [ROW_W-1:0]   HEIGHT_RESET = 12'd480;
   localparam logic [ROW_W-1:0]   HEIGHT_MIN   = 12'd3;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // one line buffer entry: pixel two rows up and pixel one row up
   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_pair_type;

   // taps of one channel around the window centre
   typedef struct packed {
      logic [CHAN_W-1:0] up;
      logic [CHAN_W-1:0] dn;
      logic [CHAN_W-1:0] lf;
      logic [CHAN_W-1:0] rt;
      logic [CHAN_W-1:0] ce;
   } lap_taps_type;

endpackage

// ===== src/lefrgb_line_buf.sv =====
// ----------------------------------------------------------------------------
// lefrgb_line_buf
// dual line store: one write port, one registered read port
// ----------------------------------------------------------------------------
module lefrgb_line_buf #(
   parameter int DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  lefrgb_pkg::line_pair_type     wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output lefrgb_pkg::line_pair_type     rd_data
);

   lefrgb_pkg::line_pair_type mem [DEPTH];
   lefrgb_pkg::line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lefrgb_lap_chan.sv =====
// ----------------------------------------------------------------------------
// lefrgb_lap_chan
// absolute four-neighbour laplacian of one colour channel
// ----------------------------------------------------------------------------
module lefrgb_lap_chan (
   input  lefrgb_pkg::lap_taps_type          taps,
   output logic [lefrgb_pkg::MAG_W-1:0]      mag
);

   logic [lefrgb_pkg::MAG_W-1:0]   nb_sum;
   logic signed [lefrgb_pkg::MAG_W:0] diff;
   logic signed [lefrgb_pkg::MAG_W:0] diff_abs;

   always_comb begin
      nb_sum = lefrgb_pkg::MAG_W'(taps.up) + lefrgb_pkg::MAG_W'(taps.dn)
             + lefrgb_pkg::MAG_W'(taps.lf) + lefrgb_pkg::MAG_W'(taps.rt);
      // centre times four is a two-bit shift
      diff = $signed({1'b0, nb_sum}) - $signed({1'b0, taps.ce, 2'b00});
      diff_abs = diff[lefrgb_pkg::MAG_W] ? -diff : diff;
      mag = diff_abs[lefrgb_pkg::MAG_W-1:0];
   end

endmodule

// ===== src/laplacian_edge_filter_rgb_core.sv =====
// ----------------------------------------------------------------------------
// laplacian_edge_filter_rgb_core
// rgb four-neighbour laplacian edge filter over a raster pixel stream
// ----------------------------------------------------------------------------
// pixels enter on the req_ channel in raster order, one word per accepted
// valid/stall handshake. each interior centre yields one rsp_ word holding the
// absolute laplacian of each channel, the centre position and a frame_last
// flag; border pixels yield nothing. the word for centre (r, c) is produced by
// the pixel at (r+1, c+1).
// an accepted pixel and its line buffer read are registered in the input
// stage; the word is loaded into the output register as that stage advances.
// a new pixel is taken every cycle while rsp_stall does not hold the output
// word; the window arithmetic runs while the pixel sits in the input stage.
// image_width and image_height are to be written on the csr_ port only while idle; the block does not enforce this.
// reset clears the column and row counters and loads 640 x 480; line buffer
// and window contents are left as they are.
// when rsp_stall holds the output word, the pixel in the input stage waits
// and req_stall rises; nothing is dropped.
// ----------------------------------------------------------------------------
`include "laplacian_edge_filter_rgb_core_assert.svh"

module laplacian_edge_filter_rgb_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // pixel input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lefrgb_pkg::CHAN_W-1:0]         req_red_in,
   input  logic [lefrgb_pkg::CHAN_W-1:0]         req_green_in,
   input  logic [lefrgb_pkg::CHAN_W-1:0]         req_blue_in,
   // filter output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lefrgb_pkg::MAG_W-1:0]          rsp_red_mag,
   output logic [lefrgb_pkg::MAG_W-1:0]          rsp_green_mag,
   output logic [lefrgb_pkg::MAG_W-1:0]          rsp_blue_mag,
   output logic [lefrgb_pkg::CCOL_W-1:0]         rsp_center_col,
   output logic [lefrgb_pkg::ROW_W-1:0]          rsp_center_row,
   output logic                                  rsp_frame_last,
   // register writes
   input  logic                                  csr_write,
   input  lefrgb_pkg::csr_index_type             csr_index,
   input  logic [lefrgb_pkg::ROW_W-1:0]          csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = ($clog2(MAX_WIDTH + 1) > lefrgb_pkg::WIDTH_W)
                       ? $clog2(MAX_WIDTH + 1) : lefrgb_pkg::WIDTH_W;
   localparam logic [WW-1:0] WMAX_C = WW'(MAX_WIDTH);
   localparam logic [WW-1:0] WMIN_C = WW'(3);

   // configuration
   logic [lefrgb_pkg::WIDTH_W-1:0] width_ff;
   logic [lefrgb_pkg::ROW_W-1:0]   height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lefrgb_pkg::WIDTH_RESET;
         height_ff <= lefrgb_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            lefrgb_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[lefrgb_pkg::WIDTH_W-1:0];
            end
            lefrgb_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata;
            end
         endcase
      end
   end

   // saturated frame geometry
   logic [WW-1:0]               width_ext;
   logic [WW-1:0]               width_eff;
   logic [WW-1:0]               col_last;
   logic [lefrgb_pkg::ROW_W-1:0] height_eff;
   logic [lefrgb_pkg::ROW_W-1:0] row_last;

   always_comb begin
      width_ext = WW'(width_ff);
      if (width_ext < WMIN_C) begin
         width_eff = WMIN_C;
      end else if (width_ext > WMAX_C) begin
         width_eff = WMAX_C;
      end else begin
         width_eff = width_ext;
      end
      col_last   = width_eff - WW'(1);
      height_eff = (height_ff < lefrgb_pkg::HEIGHT_MIN) ? lefrgb_pkg::HEIGHT_MIN : height_ff;
      row_last   = height_eff - lefrgb_pkg::ROW_W'(1);
   end

   // handshake
   logic s1_valid_ff;
   logic s1_adv;
   logic req_accept;
   logic rsp_valid_ff;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   // raster position of the next incoming pixel
   logic [CW-1:0]                col_count_ff;
   logic [lefrgb_pkg::ROW_W-1:0] row_count_ff;
   logic [WW-1:0]                col_ext;
   logic                         at_row_end;

   assign col_ext    = WW'(col_count_ff);
   assign at_row_end = col_ext >= col_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (req_accept) begin
         if (at_row_end) begin
            col_count_ff <= '0;
            row_count_ff <= (row_count_ff >= row_last) ? '0
                            : row_count_ff + lefrgb_pkg::ROW_W'(1);
         end else begin
            col_count_ff <= col_count_ff + CW'(1);
         end
      end
   end

   // result qualification worked out at accept time
   logic                          emit_in;
   logic                          last_in;
   logic [CW+lefrgb_pkg::CCOL_W-1:0] ccol_wide;

   always_comb begin
      emit_in = (row_count_ff >= lefrgb_pkg::ROW_W'(2)) && (col_ext >= WW'(2))
                && (col_ext <= col_last) && (row_count_ff <= row_last);
      last_in = (col_ext == col_last) && (row_count_ff == row_last);
      ccol_wide = (CW + lefrgb_pkg::CCOL_W)'(col_count_ff)
                  - (CW + lefrgb_pkg::CCOL_W)'(1);
   end

   // input stage
   lefrgb_pkg::pixel_type        s1_px_ff;
   logic [CW-1:0]                s1_col_ff;
   logic                         s1_emit_ff;
   logic                         s1_last_ff;
   logic [lefrgb_pkg::CCOL_W-1:0] s1_ccol_ff;
   logic [lefrgb_pkg::ROW_W-1:0]  s1_crow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_px_ff   <= '{red: req_red_in, green: req_green_in, blue: req_blue_in};
         s1_col_ff  <= col_count_ff;
         s1_emit_ff <= emit_in;
         s1_last_ff <= last_in;
         s1_ccol_ff <= ccol_wide[lefrgb_pkg::CCOL_W-1:0];
         s1_crow_ff <= row_count_ff - lefrgb_pkg::ROW_W'(1);
      end
   end

   // line buffer: read at accept, write back the shifted pair as the word leaves
   lefrgb_pkg::line_pair_type rd_pair;
   lefrgb_pkg::line_pair_type wr_pair;

   assign wr_pair = '{upper: rd_pair.middle, middle: s1_px_ff};

   lefrgb_line_buf #(
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (wr_pair),
      .rd_en   (req_accept),
      .rd_addr (col_count_ff),
      .rd_data (rd_pair)
   );

   // window: newest column plus the current centre
   lefrgb_pkg::pixel_type win_up_ff;
   lefrgb_pkg::pixel_type win_mid_ff;
   lefrgb_pkg::pixel_type win_dn_ff;
   lefrgb_pkg::pixel_type win_left_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_left_ff <= win_mid_ff;
         win_up_ff   <= rd_pair.upper;
         win_mid_ff  <= rd_pair.middle;
         win_dn_ff   <= s1_px_ff;
      end
   end

   // after the shift: up and down from the old right column, left is the old
   // centre, centre is the old middle right, right is the fresh middle read
   lefrgb_pkg::lap_taps_type taps_red;
   lefrgb_pkg::lap_taps_type taps_green;
   lefrgb_pkg::lap_taps_type taps_blue;
   logic [lefrgb_pkg::MAG_W-1:0] mag_red;
   logic [lefrgb_pkg::MAG_W-1:0] mag_green;
   logic [lefrgb_pkg::MAG_W-1:0] mag_blue;

   assign taps_red   = '{up: win_up_ff.red,   dn: win_dn_ff.red,   lf: win_left_ff.red,
                         rt: rd_pair.middle.red,   ce: win_mid_ff.red};
   assign taps_green = '{up: win_up_ff.green, dn: win_dn_ff.green, lf: win_left_ff.green,
                         rt: rd_pair.middle.green, ce: win_mid_ff.green};
   assign taps_blue  = '{up: win_up_ff.blue,  dn: win_dn_ff.blue,  lf: win_left_ff.blue,
                         rt: rd_pair.middle.blue,  ce: win_mid_ff.blue};

   lefrgb_lap_chan u_lap_red   (.taps (taps_red),   .mag (mag_red));
   lefrgb_lap_chan u_lap_green (.taps (taps_green), .mag (mag_green));
   lefrgb_lap_chan u_lap_blue  (.taps (taps_blue),  .mag (mag_blue));

   // output register
   logic [lefrgb_pkg::MAG_W-1:0]  red_mag_ff;
   logic [lefrgb_pkg::MAG_W-1:0]  green_mag_ff;
   logic [lefrgb_pkg::MAG_W-1:0]  blue_mag_ff;
   logic [lefrgb_pkg::CCOL_W-1:0] center_col_ff;
   logic [lefrgb_pkg::ROW_W-1:0]  center_row_ff;
   logic                          frame_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_emit_ff;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         red_mag_ff    <= mag_red;
         green_mag_ff  <= mag_green;
         blue_mag_ff   <= mag_blue;
         center_col_ff <= s1_ccol_ff;
         center_row_ff <= s1_crow_ff;
         frame_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_mag    = red_mag_ff;
   assign rsp_green_mag  = green_mag_ff;
   assign rsp_blue_mag   = blue_mag_ff;
   assign rsp_center_col = center_col_ff;
   assign rsp_center_row = center_row_ff;
   assign rsp_frame_last = frame_last_ff;

   // checks
   `LEF_ASSERT_NOW(a_stall_needs_word, req_stall, s1_valid_ff, "stall with empty input stage")
   `LEF_ASSERT_NEXT(a_emit_reaches_out, s1_adv && s1_emit_ff, rsp_valid_ff,
      "qualified word did not reach output")
   `LEF_ASSERT_NOW(a_mag_range, rsp_valid_ff,
      (red_mag_ff <= 10'd1020) && (green_mag_ff <= 10'd1020) && (blue_mag_ff <= 10'd1020),
      "magnitude above full scale")
   `LEF_ASSERT_NOW(a_centre_interior, rsp_valid_ff,
      (center_row_ff != '0) && (center_col_ff != '0), "border centre emitted")
   `LEF_ASSERT_NOW(a_col_in_range, 1'b1, col_ext < WMAX_C, "column count past line buffer")

endmodule

// ===== verif/tb_laplacian_edge_filter_rgb_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_laplacian_edge_filter_rgb_core
// self-checking bench for the rgb four-neighbour laplacian filter: raster
// pixels go in through a bursty driver, and every filter word that comes out
// is checked in order against a line-store and window predictor held here
// ----------------------------------------------------------------------------
module tb_laplacian_edge_filter_rgb_core;

   localparam int MAX_W         = 1024;
   localparam int RANDOM_PIXELS = 400;
   localparam int LONG_HOLD     = 250;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [lefrgb_pkg::MAG_W-1:0]  red_mag;
      logic [lefrgb_pkg::MAG_W-1:0]  green_mag;
      logic [lefrgb_pkg::MAG_W-1:0]  blue_mag;
      logic [lefrgb_pkg::CCOL_W-1:0] center_col;
      logic [lefrgb_pkg::ROW_W-1:0]  center_row;
      logic                          frame_last;
   } edge_word_type;

   typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_SMOOTH} fill_style_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [lefrgb_pkg::CHAN_W-1:0]    req_red_in = '0;
   logic [lefrgb_pkg::CHAN_W-1:0]    req_green_in = '0;
   logic [lefrgb_pkg::CHAN_W-1:0]    req_blue_in = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [lefrgb_pkg::MAG_W-1:0]     rsp_red_mag;
   logic [lefrgb_pkg::MAG_W-1:0]     rsp_green_mag;
   logic [lefrgb_pkg::MAG_W-1:0]     rsp_blue_mag;
   logic [lefrgb_pkg::CCOL_W-1:0]    rsp_center_col;
   logic [lefrgb_pkg::ROW_W-1:0]     rsp_center_row;
   logic                             rsp_frame_last;
   logic                             csr_write = 1'b0;
   lefrgb_pkg::csr_index_type        csr_index = lefrgb_pkg::CSR_IMAGE_WIDTH;
   logic [lefrgb_pkg::ROW_W-1:0]     csr_wdata = '0;

   // predictor state
   lefrgb_pkg::pixel_type            upper_line [MAX_W];
   lefrgb_pkg::pixel_type            middle_line [MAX_W];
   lefrgb_pkg::pixel_type            win [3][3];
   int unsigned                      col_pos = 0;
   int unsigned                      row_pos = 0;
   logic [lefrgb_pkg::WIDTH_W-1:0]   cfg_width = lefrgb_pkg::WIDTH_RESET;
   logic [lefrgb_pkg::ROW_W-1:0]     cfg_height = lefrgb_pkg::HEIGHT_RESET;

   lefrgb_pkg::pixel_type            pixel_backlog [$];
   edge_word_type                    pending_edges [$];
   edge_word_type                    got_word;
   edge_word_type                    want_word;
   lefrgb_pkg::pixel_type            offered_px;
   logic                             in_taken = 1'b0;

   int unsigned         pixels_taken = 0;
   int unsigned         words_checked = 0;
   int unsigned         fail_count = 0;
   int unsigned         reg_writes = 0;
   int unsigned         random_pixels = 0;
   int unsigned         holds_asked = 0;
   int unsigned         holds_granted = 0;
   int                  hold_left = 0;
   int                  burst_left = 0;
   int                  gap_left = 0;
   int unsigned         smooth_level = 128;
   logic [15:0]         stall_pattern = '0;
   logic [5:0]          pattern_age = '0;

   laplacian_edge_filter_rgb_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red_mag    (rsp_red_mag),
      .rsp_green_mag  (rsp_green_mag),
      .rsp_blue_mag   (rsp_blue_mag),
      .rsp_center_col (rsp_center_col),
      .rsp_center_row (rsp_center_row),
      .rsp_frame_last (rsp_frame_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned eff_width();
      if (cfg_width < 3) return 3;
      if (cfg_width > MAX_W) return MAX_W;
      return int'(cfg_width);
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_height < lefrgb_pkg::HEIGHT_MIN) ? int'(lefrgb_pkg::HEIGHT_MIN)
                                                   : int'(cfg_height);
   endfunction

   function automatic logic [lefrgb_pkg::MAG_W-1:0] lap_mag(
      input logic [lefrgb_pkg::CHAN_W-1:0] up, dn, lf, rt, ce);
      int sum;
      sum = int'(up) + int'(dn) + int'(lf) + int'(rt) - 4 * int'(ce);
      if (sum < 0) sum = -sum;
      return lefrgb_pkg::MAG_W'(sum);
   endfunction

   // advances the line stores, window and counters by one pixel; returns 1
   // when the pixel completes the window of an interior centre
   function automatic logic filter_pixel(input lefrgb_pkg::pixel_type px,
                                         output edge_word_type res);
      int unsigned           w_eff;
      int unsigned           h_eff;
      int unsigned           c;
      int unsigned           r;
      lefrgb_pkg::pixel_type up_px;
      lefrgb_pkg::pixel_type mid_px;
      logic                  hit;
      w_eff = eff_width();
      h_eff = eff_height();
      c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
      r = row_pos;
      up_px = upper_line[c];
      mid_px = middle_line[c];
      upper_line[c] = mid_px;
      middle_line[c] = px;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = up_px;
      win[1][2] = mid_px;
      win[2][2] = px;
      hit = (r >= 2) && (c >= 2) && (c <= w_eff - 1) && (r <= h_eff - 1);
      res = '0;
      if (hit) begin
         res.red_mag = lap_mag(win[0][1].red, win[2][1].red, win[1][0].red,
                               win[1][2].red, win[1][1].red);
         res.green_mag = lap_mag(win[0][1].green, win[2][1].green, win[1][0].green,
                                 win[1][2].green, win[1][1].green);
         res.blue_mag = lap_mag(win[0][1].blue, win[2][1].blue, win[1][0].blue,
                                win[1][2].blue, win[1][1].blue);
         res.center_col = lefrgb_pkg::CCOL_W'(c - 1);
         res.center_row = lefrgb_pkg::ROW_W'(r - 1);
         res.frame_last = (c == w_eff - 1) && (r == h_eff - 1);
      end
      if (c >= w_eff - 1) begin
         col_pos = 0;
         row_pos = (r >= h_eff - 1) ? 0 : (r + 1) & 12'hFFF;
      end else begin
         col_pos = c + 1;
      end
      return hit;
   endfunction

   // pixels still needed before both counters are back at zero
   function automatic int unsigned pixels_to_frame_end();
      int unsigned c;
      int unsigned r;
      int unsigned n;
      c = col_pos;
      r = row_pos;
      n = 0;
      while (c != 0 || r != 0) begin
         if (c >= MAX_W) c = MAX_W - 1;
         if (c >= eff_width() - 1) begin
            c = 0;
            r = (r >= eff_height() - 1) ? 0 : (r + 1) & 12'hFFF;
         end else begin
            c = c + 1;
         end
         n = n + 1;
      end
      return n;
   endfunction

   function automatic logic [lefrgb_pkg::CHAN_W-1:0] next_channel(
      input fill_style_type style);
      case (style)
         FILL_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         FILL_SMOOTH:  return lefrgb_pkg::CHAN_W'(smooth_level + $urandom_range(0, 3));
         default:      return lefrgb_pkg::CHAN_W'($urandom);
      endcase
   endfunction

   task automatic push_pixels(input int unsigned count, input fill_style_type style);
      lefrgb_pkg::pixel_type px;
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(0, 15) == 0) smooth_level = $urandom_range(0, 252);
         px.red = next_channel(style);
         px.green = next_channel(style);
         px.blue = next_channel(style);
         pixel_backlog.push_back(px);
      end
   endtask

   task automatic push_plus_frame(input lefrgb_pkg::pixel_type centre,
                                  input lefrgb_pkg::pixel_type ring);
      for (int i = 0; i < 9; i++) begin
         pixel_backlog.push_back((i == 4) ? centre : ring);
      end
   endtask

   task automatic write_reg(input lefrgb_pkg::csr_index_type idx, input int unsigned value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= lefrgb_pkg::ROW_W'(value);
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == lefrgb_pkg::CSR_IMAGE_WIDTH) begin
         cfg_width = lefrgb_pkg::WIDTH_W'(value);
      end else begin
         cfg_height = lefrgb_pkg::ROW_W'(value);
      end
      reg_writes++;
   endtask

   // all pixels taken, all words back, then a settling wait so that pixels
   // that give no word can drain out of the pipeline
   task automatic wait_idle();
      while (pixel_backlog.size() != 0 || req_valid || pending_edges.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // pixel driver: bursts of random length with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || in_taken) begin
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pixel_backlog.size() != 0) begin
            offered_px = pixel_backlog.pop_front();
            req_valid <= 1'b1;
            req_red_in <= offered_px.red;
            req_green_in <= offered_px.green;
            req_blue_in <= offered_px.blue;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // output stall: a random 16-bit pattern, redrawn whenever the pattern age wraps, or a long hold
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (holds_granted != holds_asked) begin
         holds_granted = holds_granted + 1;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = '0;
               1: stall_pattern = 16'($urandom);
               2: stall_pattern = 16'($urandom & $urandom);
               default: stall_pattern = 16'($urandom | $urandom);
            endcase
         end
         rsp_stall <= stall_pattern[pattern_age[3:0]];
         pattern_age = pattern_age + 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         in_taken <= 1'b0;
      end else begin
         in_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            pixels_taken++;
            if (filter_pixel({req_red_in, req_green_in, req_blue_in}, want_word))
               pending_edges.push_back(want_word);
         end
         if (rsp_valid && !rsp_stall) begin
            got_word = {rsp_red_mag, rsp_green_mag, rsp_blue_mag, rsp_center_col,
                        rsp_center_row, rsp_frame_last};
            if (pending_edges.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: unexpected word at centre col %0d row %0d", $time,
                           rsp_center_col, rsp_center_row);
            end else begin
               want_word = pending_edges.pop_front();
               words_checked++;
               if (got_word !== want_word) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("%0t: expected r %0d g %0d b %0d col %0d row %0d last %0b",
                              $time, want_word.red_mag, want_word.green_mag,
                              want_word.blue_mag, want_word.center_col,
                              want_word.center_row, want_word.frame_last);
                     $display("%0t:      got r %0d g %0d b %0d col %0d row %0d last %0b",
                              $time, got_word.red_mag, got_word.green_mag,
                              got_word.blue_mag, got_word.center_col,
                              got_word.center_row, got_word.frame_last);
                  end
               end
            end
         end
      end
   end

   initial begin
      int unsigned    w;
      int unsigned    h;
      int unsigned    n;
      int unsigned    frames;
      int unsigned    phase;
      fill_style_type style;
      foreach (upper_line[i]) begin
         upper_line[i] = '0;
         middle_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // smallest frames: full-scale positive and negative responses
      write_reg(lefrgb_pkg::CSR_IMAGE_WIDTH, 3);
      write_reg(lefrgb_pkg::CSR_IMAGE_HEIGHT, 3);
      push_plus_frame('{red: 8'hFF, green: 8'hFF, blue: 8'hFF}, '0);
      wait_idle();
      // below-range sizes saturate to three
      write_reg(lefrgb_pkg::CSR_IMAGE_WIDTH, 0);
      write_reg(lefrgb_pkg::CSR_IMAGE_HEIGHT, 0);
      push_plus_frame('{red: 8'hFF, green: 8'h00, blue: 8'h80},
                      '{red: 8'h00, green: 8'hFF, blue: 8'h80});
      wait_idle();

      // widest line: over-range width saturates, then the exact maximum
      write_reg(lefrgb_pkg::CSR_IMAGE_WIDTH, 2047);
      write_reg(lefrgb_pkg::CSR_IMAGE_HEIGHT, 4095);
      push_pixels(1030, FILL_RANDOM);
      wait_idle();
      write_reg(lefrgb_pkg::CSR_IMAGE_WIDTH, 1024);
      push_pixels(1026, FILL_SMOOTH);
      wait_idle();
      // narrow the line mid-row, then cut the height below the current row
      write_reg(lefrgb_pkg::CSR_IMAGE_WIDTH, 5);
      push_pixels(16, FILL_EXTREME);
      wait_idle();
      write_reg(lefrgb_pkg::CSR_IMAGE_HEIGHT, 4);
      push_pixels(pixels_to_frame_end(), FILL_RANDOM);
      wait_idle();

      phase = 0;
      while (random_pixels < RANDOM_PIXELS || phase < 4) begin
         if (phase == 3) begin
            w = 16;
            h = 8;
            frames = 2;
         end else begin
            case ($urandom_range(0, 9))
               0: w = $urandom_range(0, 2);
               1, 2: w = $urandom_range(13, 40);
               default: w = $urandom_range(3, 12);
            endcase
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
            frames = $urandom_range(1, 3);
         end
         style = fill_style_type'($urandom_range(0, 2));
         write_reg(lefrgb_pkg::CSR_IMAGE_WIDTH, w);
         write_reg(lefrgb_pkg::CSR_IMAGE_HEIGHT, h);
         n = frames * eff_width() * eff_height();
         if (phase == 1) begin
            // sender stops mid-frame until the output has drained
            push_pixels(n / 2, style);
            wait_idle();
            push_pixels(n - n / 2, style);
         end else begin
            push_pixels(n, style);
            if (phase == 3) holds_asked++;
         end
         random_pixels += n;
         wait_idle();
         phase++;
      end

      wait_idle();
      $display("covered %0d pixels in %0d frame phases with %0d register writes",
               pixels_taken, phase + 4, reg_writes);
      $display("checked %0d filter words, %0d failures, %0d words outstanding",
               words_checked, fail_count, pending_edges.size());
      if (fail_count == 0 && pending_edges.size() == 0) begin
         $display("[laplacian_edge_filter_rgb_core] OK");
      end else begin
         $display("[laplacian_edge_filter_rgb_core] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[laplacian_edge_filter_rgb_core] ERROR");
      $finish;
   end

endmodule
